// ===== src/register_address_remap_table_assert.svh =====
// assertion macros for the register address remap table
`ifndef REGISTER_ADDRESS_REMAP_TABLE_ASSERT_SVH
`define REGISTER_ADDRESS_REMAP_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define RART_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RART_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RART_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RART_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== src/rart_pkg.sv =====
// ----------------------------------------------------------------------------
// rart_pkg
// types and constants shared by the remap table modules
// ----------------------------------------------------------------------------
package rart_pkg;

  localparam int TableEntries = 1024;
  localparam int MaxDevices   = 16;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int CntW         = $clog2(TableEntries + 1);
  localparam int DevCntW      = $clog2(MaxDevices + 1);
  localparam int QDepth       = 2;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SIZE     = 3'd1,
    ST_COUNT    = 3'd2,
    ST_ALIGN    = 3'd3,
    ST_UNMAPPED = 3'd4,
    ST_DEVICES  = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_CMP  = 2'd2,
    BK_DONE = 2'd3
  } back_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        first_of_mapping;
    logic        linear_mode;
    logic [31:0] map_offset;
    logic [31:0] view_address;
    logic [31:0] device_index;
    logic [31:0] access_address;
    logic [3:0]  access_size;
    logic [3:0]  access_count;
    logic [31:0] write_data;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        forward_valid;
    logic        forward_write;
    logic [3:0]  target_device;
    logic [31:0] target_address;
    logic [31:0] forward_data;
    logic [31:0] aperture;
  } out_word_t;

  // classified work passed from front to back
  typedef struct packed {
    logic        lookup;   // 1: search the table, else report fixed result
    logic        do_write; // 1: store a new entry
    logic [2:0]  status;
    logic        is_write;
    logic [31:0] addr;     // lookup address or new entry view address
    logic [31:0] index;    // new entry target index
    logic [3:0]  device;
    logic [31:0] data;
    logic [31:0] aperture;
  } task_t;

endpackage

// ===== src/rart_front.sv =====
// ----------------------------------------------------------------------------
// rart_front
// classifies items and keeps mapping bookkeeping
// ----------------------------------------------------------------------------
module rart_front import rart_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     take,
  input  in_word_t item,
  output task_t    job
);

  logic [DevCntW-1:0] device_count, device_count_next;
  logic [31:0]        mapping_position, mapping_position_next;
  logic [31:0]        mapping_max_address, mapping_max_address_next;
  logic               mapping_refused, mapping_refused_next;
  logic [31:0]        aperture_value, aperture_value_next;
  logic [31:0]        vaddr;
  logic [31:0]        max_new;

  assign vaddr = item.map_offset + item.view_address;

  always_comb begin
    device_count_next        = device_count;
    mapping_position_next    = mapping_position;
    mapping_max_address_next = mapping_max_address;
    mapping_refused_next     = mapping_refused;
    aperture_value_next      = aperture_value;
    max_new                  = '0;
    job          = '0;
    job.is_write = (item.operation == OP_WRITE);
    job.addr     = item.access_address;
    job.data     = item.write_data;
    job.status   = ST_OK;
    unique case (op_t'(item.operation))
      OP_MAP: begin
        job.addr = vaddr;
        if (item.first_of_mapping && device_count >= DevCntW'(MaxDevices)) begin
          mapping_refused_next = 1'b1;
          job.status = ST_DEVICES;
        end else if (!item.first_of_mapping &&
                     (mapping_refused || device_count == '0)) begin
          job.status = ST_DEVICES;
        end else begin
          if (item.first_of_mapping) begin
            mapping_refused_next = 1'b0;
            device_count_next    = device_count + 1'b1;
            max_new              = '0;
            job.index = item.linear_mode ? 32'd0 : item.device_index;
            mapping_position_next = 32'd1;
          end else begin
            max_new   = mapping_max_address;
            job.index = item.linear_mode ? mapping_position : item.device_index;
            mapping_position_next = mapping_position + 32'd1;
          end
          if (vaddr > max_new) max_new = vaddr;
          mapping_max_address_next = max_new;
          aperture_value_next      = max_new + 32'd4;
          job.device   = 4'(device_count_next - 1'b1);
          job.do_write = 1'b1;
        end
      end
      OP_READ, OP_WRITE: begin
        if (item.access_size != 4'd4)       job.status = ST_SIZE;
        else if (item.access_count != 4'd1) job.status = ST_COUNT;
        else if (item.access_address[1:0] != 2'b00) job.status = ST_ALIGN;
        else begin
          job.status = ST_UNMAPPED;
          job.lookup = 1'b1;
        end
      end
      default: job.status = ST_OK;
    endcase
    job.aperture = aperture_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_count        <= '0;
      mapping_position    <= '0;
      mapping_max_address <= '0;
      mapping_refused     <= 1'b0;
      aperture_value      <= '0;
    end else if (take) begin
      device_count        <= device_count_next;
      mapping_position    <= mapping_position_next;
      mapping_max_address <= mapping_max_address_next;
      mapping_refused     <= mapping_refused_next;
      aperture_value      <= aperture_value_next;
    end
  end

endmodule

// ===== src/rart_queue.sv =====
// ----------------------------------------------------------------------------
// rart_queue
// short fifo of classified jobs between front and back
// ----------------------------------------------------------------------------
module rart_queue import rart_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  task_t push_job,
  input  logic  pop,
  output logic  full,
  output logic  empty,
  output task_t head
);

  localparam int PtrW = $clog2(QDepth);

  task_t           slots [QDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   fill;

  assign full  = (fill == (PtrW+1)'(QDepth));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== src/rart_back.sv =====
// ----------------------------------------------------------------------------
// rart_back
// stores entries and scans the table for lookups
// ----------------------------------------------------------------------------
`include "register_address_remap_table_assert.svh"
module rart_back import rart_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      avail,
  input  task_t     job,
  output logic      pop,
  output logic      done,
  output out_word_t result
);

  logic [31:0] mem_addr [TableEntries];
  logic [35:0] mem_info [TableEntries];

  back_state_t state, state_next;
  logic [CntW-1:0] entry_count;
  logic [CntW-1:0] scan;
  logic [31:0]     rd_addr;
  logic [35:0]     rd_info;
  task_t           cur;
  logic            hit;
  logic            scan_end;
  out_word_t       pop_word;

  always_ff @(posedge clk) begin
    if (pop && job.do_write && entry_count < CntW'(TableEntries)) begin
      mem_addr[entry_count[IdxW-1:0]] <= job.addr;
      mem_info[entry_count[IdxW-1:0]] <= {job.device, job.index};
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= mem_addr[scan[IdxW-1:0]];
    rd_info <= mem_info[scan[IdxW-1:0]];
  end

  assign hit      = (rd_addr == cur.addr);
  assign scan_end = (scan + 1'b1 >= entry_count);

  // result word as known when the job is taken; a lookup miss keeps it
  always_comb begin
    pop_word          = '0;
    pop_word.status   = (job.do_write && entry_count >= CntW'(TableEntries)) ?
                        ST_FULL : job.status;
    pop_word.aperture = job.aperture;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (avail) state_next = (job.lookup && entry_count != '0) ? BK_READ : BK_DONE;
      BK_READ: state_next = BK_CMP;
      BK_CMP:  state_next = (hit || scan_end) ? BK_DONE : BK_READ;
      BK_DONE: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == BK_IDLE) && avail;
    done = (state == BK_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BK_IDLE;
      entry_count <= '0;
      scan        <= '0;
    end else begin
      state <= state_next;
      if (pop) begin
        scan <= '0;
        if (job.do_write && entry_count < CntW'(TableEntries))
          entry_count <= entry_count + 1'b1;
      end else if (state == BK_CMP && !hit) begin
        scan <= scan + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur    <= job;
      result <= pop_word;
    end else if (state == BK_CMP && hit) begin
      result.status         <= ST_OK;
      result.forward_valid  <= 1'b1;
      result.forward_write  <= cur.is_write;
      result.target_device  <= rd_info[35:32];
      result.target_address <= {rd_info[29:0], 2'b00};
      result.forward_data   <= cur.is_write ? cur.data : 32'd0;
    end
  end

  `RART_ASSERT_IMP(a_done_one, clk, rst, done, !pop, "result and pop overlap")
  `RART_ASSERT_NEXT(a_done_idle, clk, rst, done, state == BK_IDLE, "no return to idle")
  `RART_ASSERT_IMP(a_cnt, clk, rst, 1'b1, entry_count <= CntW'(TableEntries), "count overflow")

endmodule

// ===== src/register_address_remap_table.sv =====
// ----------------------------------------------------------------------------
// register_address_remap_table
// map, op three and rejected words pass through the job queue, the back-end idle pop and its done state to the strobe
// lookups step through the read and compare states per entry scanned, scan runs over stored entries
// back end takes no new job until the current one is done; results cannot be held off
// a new word is taken while the two-deep job queue has room
// reset clears counts and mapping state; table contents stay undefined
// ----------------------------------------------------------------------------
`include "register_address_remap_table_assert.svh"
module register_address_remap_table import rart_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_word_t  request,
  output logic      busy,
  output logic      strobe,
  output out_word_t response
);

  // front to back job path
  task_t front_job;
  task_t head_job;
  logic  q_full, q_empty, pop;
  logic  take;

  // queue room gates new words
  assign busy = q_full;
  assign take = start && !busy;

  rart_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (request),
    .job  (front_job)
  );

  rart_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (take),
    .push_job (front_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head_job)
  );

  // back end scans table and emits one result per job
  rart_back u_back (
    .clk    (clk),
    .rst    (rst),
    .avail  (!q_empty),
    .job    (head_job),
    .pop    (pop),
    .done   (strobe),
    .result (response)
  );

  `RART_ASSERT_IMP(a_no_push_full, clk, rst, take, !q_full, "push into full queue")
  `RART_ASSERT_IMP(a_pop_nonempty, clk, rst, pop, !q_empty, "pop from empty queue")
  `RART_ASSERT_IMP(a_fwd_ok, clk, rst, strobe && response.forward_valid,
                   response.status == ST_OK, "forward with bad status")

endmodule
